>>> hdl/rpt_pkg.sv
// shared types and constants for the rtt probe tracker
`timescale 1ns / 1ps
`default_nettype none
package rpt_pkg;
   localparam int unsigned RttMax   = 65535;
   localparam int unsigned NoRtt    = 100000;
   localparam logic [1:0]  CmdSend  = 2'd0;
   localparam logic [1:0]  CmdReply = 2'd1;
   localparam logic [1:0]  RegInterval = 2'd0;
   localparam logic [1:0]  RegPenalty  = 2'd1;
   localparam logic [1:0]  RegTimeout  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] time_ms;
      logic [15:0] reply_id;
      logic [15:0] sender_id;
   } req_type;

   typedef struct packed {
      logic signed [16:0] result_value;
      logic               probe_sent;
      logic [15:0]        probe_out_id;
      logic [15:0]        probe_out_sender;
      logic               echo_reply;
      logic [15:0]        average_ms;
      logic [16:0]        lowest_ms;
      logic [8:0]         loss_fraction;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_APPLY, ST_STATS, ST_DIV_START, ST_DIV_AVG, ST_DIV_LOSS, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_step;
      logic scan_clear;
      logic apply;
      logic div_start_avg;
      logic div_start_loss;
      logic div_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic div_last;
   } sts_type;
endpackage
`default_nettype wire

>>> hdl/rpt_ctrl.sv
// controller sequencing scan, update, statistics and divides
`timescale 1ns / 1ps
`default_nettype none
module rpt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rpt_pkg::sts_type sts,
   output rpt_pkg::cmd_type      cmd
);
   rpt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpt_pkg::ST_IDLE: begin
            if (req_valid) state_in = rpt_pkg::ST_SCAN;
         end
         rpt_pkg::ST_SCAN: begin
            if (sts.scan_last) state_in = rpt_pkg::ST_APPLY;
         end
         rpt_pkg::ST_APPLY: begin
            state_in = rpt_pkg::ST_STATS;
         end
         rpt_pkg::ST_STATS: begin
            if (sts.scan_last) state_in = rpt_pkg::ST_DIV_START;
         end
         rpt_pkg::ST_DIV_START: begin
            state_in = rpt_pkg::ST_DIV_AVG;
         end
         rpt_pkg::ST_DIV_AVG: begin
            if (sts.div_last) state_in = rpt_pkg::ST_DIV_LOSS;
         end
         rpt_pkg::ST_DIV_LOSS: begin
            if (sts.div_last) state_in = rpt_pkg::ST_DONE;
         end
         rpt_pkg::ST_DONE: begin
            if (!rsp_valid || rsp_ready) state_in = rpt_pkg::ST_IDLE;
         end
         default: state_in = rpt_pkg::ST_IDLE;
      endcase
   end

   logic busy_out_ff, busy_out_in;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_out_ff <= 1'b0;
      end else begin
         busy_out_ff <= busy_out_in;
      end
   end
   assign rsp_valid = busy_out_ff;

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      busy_out_in = busy_out_ff && !rsp_ready;
      case (state_ff)
         rpt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         rpt_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         rpt_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
            cmd.scan_clear = 1'b1;
         end
         rpt_pkg::ST_STATS: begin
            cmd.scan_step = 1'b1;
         end
         rpt_pkg::ST_DIV_START: begin
            cmd.div_start_avg = 1'b1;
         end
         rpt_pkg::ST_DIV_AVG: begin
            cmd.div_step = !sts.div_last;
            cmd.div_start_loss = sts.div_last;
         end
         rpt_pkg::ST_DIV_LOSS: begin
            cmd.div_step = !sts.div_last;
         end
         rpt_pkg::ST_DONE: begin
            if (!busy_out_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               busy_out_in = 1'b1;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

>>> hdl/rpt_path.sv
// history registers, scan, update and serial divider
`timescale 1ns / 1ps
`default_nettype none
module rpt_path #(
   parameter int unsigned HISTORY_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_data,
   input  wire rpt_pkg::req_type req_data,
   input  wire rpt_pkg::cmd_type cmd,
   output rpt_pkg::sts_type      sts,
   output rpt_pkg::rsp_type      rsp_data
);
   localparam int unsigned IW = $clog2(HISTORY_DEPTH);
   localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
   localparam int unsigned SW = 16 + CW;
   localparam int unsigned DW = (SW > 17) ? SW : 17;

   logic [15:0] interval_ff, penalty_ff, timeout_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 16'd300;
         penalty_ff  <= 16'd300;
         timeout_ff  <= 16'd1000;
      end else if (csr_write) begin
         case (csr_index)
            rpt_pkg::RegInterval: interval_ff <= csr_data;
            rpt_pkg::RegPenalty:  penalty_ff  <= csr_data;
            rpt_pkg::RegTimeout:  timeout_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   logic [15:0] id_ff [HISTORY_DEPTH];
   logic [31:0] st_ff [HISTORY_DEPTH];
   logic [15:0] rtt_ff [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] ret_ff;
   logic [CW-1:0] count_ff;
   logic [15:0] next_id_ff;
   logic [31:0] next_time_ff;

   rpt_pkg::req_type req_ff;
   logic [IW-1:0] idx_ff;
   logic          run_ff;      // scan walk still inside the newest run
   logic [17:0]   est_ff;
   logic          found_ff;
   logic [IW-1:0] hit_ff;
   logic [15:0]   hit_rtt_ff;

   logic [SW-1:0] sum_ff;
   logic [CW-1:0] cnt_ff, total_ff, drop_ff;
   logic [16:0]   low_ff;
   logic          started_ff;

   logic [DW-1:0] num_ff, den_ff, quo_ff, rem_ff;
   logic [4:0]    bit_ff;
   logic [15:0]   avg_ff;

   // item fields known after the update, held until the statistics are done
   logic signed [16:0] res_ff;
   logic               sent_ff;
   logic [15:0]        pid_ff;
   logic [15:0]        psnd_ff;
   logic               echo_ff;

   // marks the second walk
   logic sts_stats_ff;

   rpt_pkg::rsp_type out_ff;
   assign rsp_data = out_ff;

   wire logic in_range = ((CW+1)'(idx_ff) < (CW+1)'(count_ff));
   assign sts.scan_last = (idx_ff == IW'(HISTORY_DEPTH - 1));
   assign sts.div_last  = (bit_ff == 5'd0);

   wire logic [31:0] age = req_ff.time_ms - st_ff[idx_ff];
   wire logic [15:0] age_sat = (age > 32'(rpt_pkg::RttMax)) ? 16'hFFFF : age[15:0];
   wire logic [31:0] diff = req_ff.time_ms - next_time_ff;
   wire logic allowed = (count_ff == '0) || !diff[31];
   wire logic [DW:0] trial = {rem_ff, num_ff[DW-1]};

   logic signed [16:0] result;
   always_comb begin
      result = -17'sd1;
      if (req_ff.command == rpt_pkg::CmdSend && allowed)
         result = (est_ff > 18'd65536) ? 17'sd65535 : 17'(est_ff - 18'd1);
      else if (req_ff.command == rpt_pkg::CmdReply && found_ff)
         result = {1'b0, hit_rtt_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ret_ff <= '0;
         count_ff <= '0;
         next_id_ff <= '0;
         next_time_ff <= '0;
      end else if (cmd.apply) begin
         if (req_ff.command == rpt_pkg::CmdSend && allowed) begin
            ret_ff <= {ret_ff[HISTORY_DEPTH-2:0], 1'b0};
            if (count_ff < CW'(HISTORY_DEPTH)) count_ff <= count_ff + 1'b1;
            next_id_ff <= next_id_ff + 16'd1;
            next_time_ff <= req_ff.time_ms + {16'd0, interval_ff};
         end else if (req_ff.command == rpt_pkg::CmdReply && found_ff) begin
            ret_ff[hit_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         if (req_ff.command == rpt_pkg::CmdSend && allowed) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
               id_ff[i]  <= id_ff[i-1];
               st_ff[i]  <= st_ff[i-1];
               rtt_ff[i] <= rtt_ff[i-1];
            end
            id_ff[0] <= next_id_ff;
            st_ff[0] <= req_ff.time_ms;
            rtt_ff[0] <= '0;
         end else if (req_ff.command == rpt_pkg::CmdReply && found_ff) begin
            rtt_ff[hit_ff] <= hit_rtt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         idx_ff <= '0;
         run_ff <= 1'b1;
         est_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         idx_ff <= '0;
         run_ff <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
         total_ff <= '0;
         drop_ff <= '0;
         low_ff <= 17'(rpt_pkg::NoRtt);
         started_ff <= 1'b0;
         res_ff <= result;
         sent_ff <= (req_ff.command == rpt_pkg::CmdSend) && allowed;
         pid_ff <= (req_ff.command == rpt_pkg::CmdSend && allowed) ? next_id_ff : 16'd0;
         psnd_ff <= (req_ff.command == rpt_pkg::CmdSend && allowed)
                    ? req_ff.sender_id : 16'd0;
         echo_ff <= (req_ff.command == rpt_pkg::CmdReply) && found_ff;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         // first walk: penalty sum and reply match over the newest run
         if (run_ff && in_range) begin
            if (!ret_ff[idx_ff] && est_ff <= 18'd65536)
               est_ff <= est_ff + {2'd0, penalty_ff};
            if (req_ff.command == rpt_pkg::CmdReply && !found_ff
                && id_ff[idx_ff] == req_ff.reply_id) begin
               found_ff <= 1'b1;
               hit_ff <= idx_ff;
               hit_rtt_ff <= age_sat;
               run_ff <= 1'b0;
            end else if (ret_ff[idx_ff]) begin
               run_ff <= 1'b0;
            end
         end
      end
      // second walk: statistics
      if (cmd.scan_step && in_range && sts_stats_ff) begin
         if (ret_ff[idx_ff]) begin
            cnt_ff <= cnt_ff + 1'b1;
            sum_ff <= sum_ff + SW'(rtt_ff[idx_ff]);
            if ({1'b0, rtt_ff[idx_ff]} < low_ff) low_ff <= {1'b0, rtt_ff[idx_ff]};
         end
         if (started_ff || ret_ff[idx_ff] || age > {16'd0, timeout_ff}) begin
            started_ff <= 1'b1;
            total_ff <= total_ff + 1'b1;
            if (!ret_ff[idx_ff]) drop_ff <= drop_ff + 1'b1;
         end
      end
      if (cmd.div_start_avg) begin
         num_ff <= DW'(sum_ff);
         den_ff <= DW'(cnt_ff);
         rem_ff <= '0;
         bit_ff <= 5'(DW);
      end else if (cmd.div_start_loss) begin
         avg_ff <= (den_ff == '0) ? 16'd0 : quo_ff[15:0];
         num_ff <= DW'({drop_ff, 8'd0});
         den_ff <= DW'(total_ff);
         rem_ff <= '0;
         bit_ff <= 5'(DW);
      end else if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= DW'(trial - {1'b0, den_ff});
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
         bit_ff <= bit_ff - 5'd1;
      end
      if (cmd.finish) begin
         out_ff.result_value <= res_ff;
         out_ff.probe_sent <= sent_ff;
         out_ff.probe_out_id <= pid_ff;
         out_ff.probe_out_sender <= psnd_ff;
         out_ff.echo_reply <= echo_ff;
         out_ff.average_ms <= avg_ff;
         out_ff.lowest_ms <= low_ff;
         out_ff.loss_fraction <= (den_ff == '0) ? 9'd0 : quo_ff[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sts_stats_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         sts_stats_ff <= 1'b1;
      end else if (cmd.div_start_avg) begin
         sts_stats_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

>>> hdl/rtt_probe_tracker.sv
// top level of the rtt probe tracker
// one item at a time: two history walks over all HISTORY_DEPTH entries (match,
// then statistics), two bit-serial divides on one shared divider and control
// states, which together set when the result is valid; a held result stalls
// the end
// synchronous reset clears history reply flags, count, id, send time, and sets registers to defaults
`timescale 1ns / 1ps
`default_nettype none
module rtt_probe_tracker #(
   parameter int unsigned HISTORY_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rpt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rpt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_data
);
   rpt_pkg::cmd_type cmd;
   rpt_pkg::sts_type sts;

   rpt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   rpt_path #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_path (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_data, .cmd, .sts,
      .rsp_data
   );
endmodule
`default_nettype wire
